// File: design/epdm_pkg.sv
// Shared constants, codes and types of the echo pulse distance meter.
// Used by epdm_capture, epdm_convert and echo_pulse_distance_meter_core.
`timescale 1ns / 1ps

package epdm_pkg;

  localparam int unsigned TimerBits   = 16;
  localparam int unsigned OvfBits     = 16;
  localparam int unsigned TickBits    = OvfBits + TimerBits;
  localparam int unsigned ScaleBits   = 16;
  localparam int unsigned MinBits     = 9;
  localparam int unsigned DistBits    = 10;
  localparam int unsigned ProdBits    = TickBits + ScaleBits;
  localparam int unsigned CfgIdxBits  = 2;
  localparam int unsigned CfgDataBits = 16;
  localparam int unsigned InDataBits  = 16;
  localparam int unsigned OutDataBits = 16;

  // Request kinds carried in the slave-side tuser.
  localparam logic [1:0] REQ_OVERFLOW = 2'd0;
  localparam logic [1:0] REQ_CAPTURE  = 2'd1;
  localparam logic [1:0] REQ_READ     = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxBits-1:0] CFG_MIN   = 2'd0;
  localparam logic [CfgIdxBits-1:0] CFG_MAX   = 2'd1;
  localparam logic [CfgIdxBits-1:0] CFG_SCALE = 2'd2;

  localparam logic [MinBits-1:0]   MinReset   = 9'd2;
  localparam logic [DistBits-1:0]  MaxReset   = 10'd400;
  localparam logic [ScaleBits-1:0] ScaleReset = 16'd8645;

  // Division by one million is split into a shift by 2^6 and a division
  // by 15625. Any product at or above 1024 million gives a distance beyond
  // every legal maximum, so only the low 30 bits of the product ever need
  // to be divided.
  localparam longint unsigned TicksPerMillion = 64'd1000000;
  localparam int unsigned     LowProdBits     = 30;
  localparam int unsigned     DivShift        = 6;
  localparam longint unsigned OddDiv          = 64'd15625;
  localparam int unsigned     QuotInBits      = LowProdBits - DivShift;
  localparam int unsigned     RecipShift      = QuotInBits + 14;
  localparam int unsigned     RecipBits       = 25;
  localparam int unsigned     QProdBits       = QuotInBits + RecipBits;

  // Rounded-up reciprocal; its error is below 2^(RecipShift - QuotInBits),
  // so the shifted product is the exact floor for every 24-bit dividend.
  localparam logic [RecipBits-1:0] Recip =
    RecipBits'(((64'd1 << RecipShift) + OddDiv - 64'd1) / OddDiv);

  localparam logic [ProdBits-1:0] ProdLimit =
    ProdBits'((64'd1 << DistBits) * TicksPerMillion);

  typedef struct packed {
    logic [MinBits-1:0]   min_dist;
    logic [DistBits-1:0]  max_dist;
    logic [ScaleBits-1:0] scale;
  } epdm_cfg_t;

  // A read request on its way to conversion: hit marks a completed pulse,
  // diff is end plus overflows minus start with the borrow on top.
  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [TickBits:0] diff;
  } epdm_tick_t;

endpackage

// File: design/echo_pulse_distance_meter_core.sv
// Top level of the echo pulse distance meter: stream ports, configuration
// registers, capture state and conversion pipeline.
// Depends on epdm_pkg, epdm_capture and epdm_convert.
`timescale 1ns / 1ps

// Timer events enter on the slave stream, one per cycle while s_axis_tready
// is high: tuser selects an overflow tick, a capture edge or a read, and
// tdata carries the captured timer value. Only reads produce a result,
// which leaves the master stream through the capture tick register, the
// two multiply stages (ticks times scale, then a reciprocal multiply that
// divides by one million) and the result register, with tuser set when a
// completed pulse was converted and tdata holding the distance (0 when out
// of range or when no pulse was complete). The pipeline takes a new request
// every cycle as long as the master side keeps up. Ticks and captures leave
// no slot in the pipeline. Configuration writes are taken at once and must
// be made while no read is in flight.
module echo_pulse_distance_meter_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Slave stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [epdm_pkg::InDataBits-1:0]    s_axis_tdata,  // [15:0] capture_value
  input  logic [1:0]                         s_axis_tuser,  // [1:0] req_type
  // Master stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [epdm_pkg::OutDataBits-1:0]   m_axis_tdata,  // [9:0] distance_cm
  output logic [0:0]                         m_axis_tuser,  // [0] new_result
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [epdm_pkg::CfgIdxBits-1:0]    cfg_index_i,
  input  logic [epdm_pkg::CfgDataBits-1:0]   cfg_data_i
);
  import epdm_pkg::*;

  epdm_cfg_t           cfg_q;
  epdm_tick_t          tick;
  logic                conv_ready;
  logic                new_result;
  logic [DistBits-1:0] distance_cm;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_dist <= MinReset;
      cfg_q.max_dist <= MaxReset;
      cfg_q.scale    <= ScaleReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_MIN:   cfg_q.min_dist <= cfg_data_i[MinBits-1:0];
        CFG_MAX:   cfg_q.max_dist <= cfg_data_i[DistBits-1:0];
        CFG_SCALE: cfg_q.scale    <= cfg_data_i[ScaleBits-1:0];
        default: begin
        end
      endcase
    end
  end

  epdm_capture u_capture (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_valid_i     (s_axis_tvalid),
    .req_type_i      (s_axis_tuser),
    .capture_value_i (s_axis_tdata[TimerBits-1:0]),
    .next_ready_i    (conv_ready),
    .req_ready_o     (s_axis_tready),
    .tick_o          (tick)
  );

  epdm_convert u_convert (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tick_i       (tick),
    .cfg_i        (cfg_q),
    .out_ready_i  (m_axis_tready),
    .in_ready_o   (conv_ready),
    .out_valid_o  (m_axis_tvalid),
    .new_result_o (new_result),
    .distance_o   (distance_cm)
  );

  assign m_axis_tdata = {{(OutDataBits - DistBits){1'b0}}, distance_cm};
  assign m_axis_tuser = new_result;

endmodule

// File: design/epdm_capture.sv
// Pulse capture state of the echo pulse distance meter: overflow count,
// start and end times, and the tick difference handed on for each read.
// Depends on epdm_pkg.
`timescale 1ns / 1ps

module epdm_capture (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic [1:0]                      req_type_i,
  input  logic [epdm_pkg::TimerBits-1:0]  capture_value_i,
  input  logic                            next_ready_i,
  output logic                            req_ready_o,
  output epdm_pkg::epdm_tick_t            tick_o
);
  import epdm_pkg::*;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_ARMED = 2'd1;
  localparam logic [1:0] PH_DONE  = 2'd2;

  logic [1:0]           phase_q, phase_d;
  logic [TimerBits-1:0] start_q, start_d;
  logic [TimerBits-1:0] end_q, end_d;
  logic [OvfBits-1:0]   run_ovf_q, run_ovf_d;
  logic [OvfBits-1:0]   lat_ovf_q, lat_ovf_d;
  epdm_tick_t           tick_q, tick_d;
  logic                 accept;

  assign req_ready_o = ~tick_q.valid | next_ready_i;
  assign accept      = req_valid_i & req_ready_o;

  always_comb begin
    phase_d   = phase_q;
    start_d   = start_q;
    end_d     = end_q;
    run_ovf_d = run_ovf_q;
    lat_ovf_d = lat_ovf_q;
    if (accept) begin
      unique case (req_type_i)
        REQ_OVERFLOW: begin
          run_ovf_d = run_ovf_q + OvfBits'(1);
        end
        REQ_CAPTURE: begin
          if (phase_q == PH_IDLE) begin
            start_d   = capture_value_i;
            run_ovf_d = '0;
            phase_d   = PH_ARMED;
          end else if (phase_q == PH_ARMED) begin
            end_d     = capture_value_i;
            lat_ovf_d = run_ovf_q;
            phase_d   = PH_DONE;
          end
        end
        REQ_READ: begin
          if (phase_q == PH_DONE) begin
            phase_d   = PH_IDLE;
            run_ovf_d = '0;
            lat_ovf_d = '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // The snapshot is taken from the state as it stands before this read.
  always_comb begin
    tick_d.valid = accept & (req_type_i == REQ_READ);
    tick_d.hit   = (phase_q == PH_DONE);
    tick_d.diff  = {1'b0, lat_ovf_q, end_q} - {{(OvfBits + 1){1'b0}}, start_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      start_q   <= '0;
      end_q     <= '0;
      run_ovf_q <= '0;
      lat_ovf_q <= '0;
      tick_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      start_q   <= start_d;
      end_q     <= end_d;
      run_ovf_q <= run_ovf_d;
      lat_ovf_q <= lat_ovf_d;
      if (req_ready_o) begin
        tick_q <= tick_d;
      end
    end
  end

  assign tick_o = tick_q;

endmodule

// File: design/epdm_convert.sv
// Conversion pipeline: ticks times scale, division by one million through
// a reciprocal multiply, range check, and the result register.
// Depends on epdm_pkg.
`timescale 1ns / 1ps

module epdm_convert (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  epdm_pkg::epdm_tick_t           tick_i,
  input  epdm_pkg::epdm_cfg_t            cfg_i,
  input  logic                           out_ready_i,
  output logic                           in_ready_o,
  output logic                           out_valid_o,
  output logic                           new_result_o,
  output logic [epdm_pkg::DistBits-1:0]  distance_o
);
  import epdm_pkg::*;

  // Stage two: tick count times scale.
  logic                v2_q, hit2_q, neg2_q;
  logic [ProdBits-1:0] prod2_q, prod2_d;
  // Stage three: reciprocal product.
  logic                 v3_q, hit3_q, over3_q, over3_d;
  logic [QProdBits-1:0] qprod3_q, qprod3_d;
  // Result register.
  logic                v4_q, new4_q;
  logic [DistBits-1:0] dist4_q, dist4_d;
  logic [DistBits-1:0] quot;
  logic                en2, en3, en4;

  assign en4 = ~v4_q | out_ready_i;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign in_ready_o = en2;

  assign prod2_d = ProdBits'(tick_i.diff[TickBits-1:0]) * ProdBits'(cfg_i.scale);

  assign over3_d  = neg2_q | (prod2_q >= ProdLimit);
  assign qprod3_d = QProdBits'(prod2_q[LowProdBits-1:DivShift]) * QProdBits'(Recip);

  // Below the product limit the quotient always fits the distance width.
  assign quot = qprod3_q[RecipShift +: DistBits];

  always_comb begin
    dist4_d = '0;
    if (hit3_q && !over3_q && (quot >= DistBits'(cfg_i.min_dist))
        && (quot <= cfg_i.max_dist)) begin
      dist4_d = quot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= tick_i.valid;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      hit2_q  <= tick_i.hit;
      neg2_q  <= tick_i.diff[TickBits];
      prod2_q <= prod2_d;
    end
    if (en3) begin
      hit3_q   <= hit2_q;
      over3_q  <= over3_d;
      qprod3_q <= qprod3_d;
    end
    if (en4) begin
      new4_q  <= hit3_q;
      dist4_q <= dist4_d;
    end
  end

  assign out_valid_o  = v4_q;
  assign new_result_o = new4_q;
  assign distance_o   = dist4_q;

endmodule
